[sv/kfc_pkg.sv]
// Package: shared types, constants and helpers for the k-mer frequency counter.
`timescale 1ns / 1ps
package kfc_pkg;
	localparam int TABLE_DEPTH = 262144;
	localparam int K_MAX       = 15;
	localparam int COUNT_BITS  = 20;
	localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
	localparam int KMER_BITS   = 2 * K_MAX;
	localparam int KLEN_BITS   = 4;
	localparam int MOD_BITS    = 18;
	localparam int MODW        = ADDR_BITS + 1;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_PUSH  = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_KMER_LEN     = 2'd0,
		REG_DIRECT_MAX_K = 2'd1,
		REG_HASH_MODULUS = 2'd2
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WIPE,
		ST_MOD,
		ST_RD,
		ST_WAIT,
		ST_CHECK,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                  used;
		logic [KMER_BITS-1:0]  key;
		logic [COUNT_BITS-1:0] count;
	} slot_t;

	typedef struct packed {
		logic                  kmer_valid;
		logic [KMER_BITS-1:0]  kmer_value;
		logic [COUNT_BITS-1:0] hit_count;
		logic [KMER_BITS-1:0]  best_kmer;
		logic [COUNT_BITS-1:0] best_count;
		logic                  table_full;
	} result_t;

	typedef struct packed {
		logic [1:0]           cmd;
		logic [1:0]           base;
		logic [KMER_BITS-1:0] query_kmer;
	} item_t;
endpackage

[sv/kfc_if.sv]
// Interfaces: input item, result item and configuration write channels.
`timescale 1ns / 1ps
interface kfc_item_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       cmd;
	logic [1:0]                       base;
	logic [kfc_pkg::KMER_BITS-1:0]    query_kmer;
	modport source (output valid, cmd, base, query_kmer, input ready);
	modport sink   (input valid, cmd, base, query_kmer, output ready);
endinterface

interface kfc_result_if;
	logic                             valid;
	logic                             ready;
	logic                             kmer_valid;
	logic [kfc_pkg::KMER_BITS-1:0]    kmer_value;
	logic [kfc_pkg::COUNT_BITS-1:0]   hit_count;
	logic [kfc_pkg::KMER_BITS-1:0]    best_kmer;
	logic [kfc_pkg::COUNT_BITS-1:0]   best_count;
	logic                             table_full;
	modport source (output valid, kmer_valid, kmer_value, hit_count, best_kmer,
		best_count, table_full, input ready);
	modport sink   (input valid, kmer_valid, kmer_value, hit_count, best_kmer,
		best_count, table_full, output ready);
endinterface

interface kfc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[sv/kfc_slot_ram.sv]
// Slot memory: one write port, one registered read port.
`timescale 1ns / 1ps
module kfc_slot_ram (
	input  logic                           clk,
	input  logic                           we,
	input  logic [kfc_pkg::ADDR_BITS-1:0]  waddr,
	input  kfc_pkg::slot_t                 wdata,
	input  logic [kfc_pkg::ADDR_BITS-1:0]  raddr,
	output kfc_pkg::slot_t                 rdata
);
	kfc_pkg::slot_t mem [kfc_pkg::TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[sv/kfc_mod_unit.sv]
// Sequential remainder unit: kmer mod modulus, one quotient bit per cycle.
`timescale 1ns / 1ps
module kfc_mod_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [kfc_pkg::KMER_BITS-1:0] dividend,
	input  logic [kfc_pkg::MODW-1:0]      divisor,
	output logic                          done,
	output logic [kfc_pkg::MODW-1:0]      remainder
);
	localparam int CNT_BITS = $clog2(kfc_pkg::KMER_BITS + 1);

	logic [kfc_pkg::KMER_BITS-1:0] num_q;
	logic [kfc_pkg::MODW:0]        rem_q;
	logic [CNT_BITS-1:0]           cnt_q;
	logic                          busy_q;
	logic [kfc_pkg::MODW:0]        shifted;

	assign shifted   = {rem_q[kfc_pkg::MODW-1:0], num_q[kfc_pkg::KMER_BITS-1]};
	assign remainder = rem_q[kfc_pkg::MODW-1:0];
	assign done      = busy_q && (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(kfc_pkg::KMER_BITS);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			num_q <= num_q << 1;
			if (shifted >= {1'b0, divisor}) begin
				rem_q <= shifted - {1'b0, divisor};
			end else begin
				rem_q <= shifted;
			end
		end
	end
endmodule

[sv/kmer_frequency_counter_core.sv]
// Top level: k-mer frequency counter with direct and linear-probing slot table.
`timescale 1ns / 1ps
// Usage:
//  item channel: cmd (0 clear, 1 push base, 2 query), base, query_kmer.
//  result channel: one word per item; kmer_valid, kmer_value, hit_count,
//   best_kmer, best_count, table_full.
//  cfg channel: index 0 kmer_len, 1 direct_max_k, 2 hash_modulus; write idle.
// One item at a time. A warm-up push or an unused command goes straight to output.
// A direct push or query steps through memory read, wait and check.
// A hashed access first runs the bit-serial remainder and then reads, waits
// and checks each probed slot, read-modify-write through the one slot memory.
// Reset, and every clear item, runs a wipe of all TABLE_DEPTH slots, one slot
// per cycle, during which no item is accepted.
// A finished word sits in the output register; while the receiver stalls,
// hold it and take no new item. Config writes are accepted at any time.
module kmer_frequency_counter_core (
	input  logic          clk,
	input  logic          arst_n,
	kfc_item_if.sink      in_item,
	kfc_result_if.source  out_res,
	kfc_cfg_if.sink       cfg
);
	localparam int AB = kfc_pkg::ADDR_BITS;
	localparam int KB = kfc_pkg::KMER_BITS;
	localparam int CB = kfc_pkg::COUNT_BITS;
	localparam int MW = kfc_pkg::MODW;

	kfc_pkg::state_t state_q, state_d;

	logic [3:0]                  klen_q, dmax_q;
	logic [kfc_pkg::MOD_BITS-1:0] hmod_q;
	logic [KB-1:0]               roll_q, kmer_q, qk_q;
	logic [3:0]                  seen_q;
	logic [KB-1:0]               best_kmer_q;
	logic [CB-1:0]               best_cnt_q;
	logic                        full_q;
	logic [1:0]                  cmd_q;
	logic [AB:0]                 idx_q, probes_q;
	logic [AB:0]                 wipe_q;
	logic                        boot_q;
	kfc_pkg::result_t            res_q;
	logic                        ovalid_q;

	// effective configuration
	logic [3:0]    keff;
	logic [MW-1:0] meff;
	logic          direct;
	logic [KB-1:0] kmask;
	always_comb begin
		keff = (klen_q == '0) ? 4'd1 : klen_q;
		if (32'(keff) > kfc_pkg::K_MAX) keff = 4'(kfc_pkg::K_MAX);
		if (hmod_q == '0) meff = MW'(1);
		else if (32'(hmod_q) > kfc_pkg::TABLE_DEPTH) meff = MW'(kfc_pkg::TABLE_DEPTH);
		else meff = MW'(hmod_q);
		direct = (keff <= dmax_q) && ((64'd1 << (2 * keff)) <= 64'(kfc_pkg::TABLE_DEPTH));
		kmask  = KB'((64'd1 << (2 * keff)) - 64'd1);
	end

	// config port
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q <= 4'd12;
			dmax_q <= 4'd9;
			hmod_q <= kfc_pkg::MOD_BITS'(4001);
		end else if (cfg.valid) begin
			case (cfg.index)
				kfc_pkg::REG_KMER_LEN:     klen_q <= cfg.data[3:0];
				kfc_pkg::REG_DIRECT_MAX_K: dmax_q <= cfg.data[3:0];
				kfc_pkg::REG_HASH_MODULUS: hmod_q <= cfg.data[kfc_pkg::MOD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// remainder unit
	logic          mod_start, mod_done;
	logic          mod_busy_q;
	logic [KB-1:0] mod_in;
	logic [MW-1:0] mod_rem;
	kfc_mod_unit u_mod (
		.clk(clk), .arst_n(arst_n), .start(mod_start), .dividend(mod_in),
		.divisor(meff), .done(mod_done), .remainder(mod_rem)
	);

	// slot memory
	logic           we;
	logic [AB-1:0]  waddr, raddr;
	kfc_pkg::slot_t wdata, rdata;
	kfc_slot_ram u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	// datapath decode
	logic [KB-1:0] new_roll, key;
	logic [3:0]    new_seen;
	logic          accept;
	logic          is_push;
	logic [AB:0]   idx_nx;
	logic          match, free;
	logic [CB-1:0] cnt_inc;
	logic [KB-1:0] acc_value;

	assign accept   = in_item.valid && in_item.ready;
	assign new_roll = {roll_q[KB-3:0], in_item.base};
	assign new_seen = (32'(seen_q) < kfc_pkg::K_MAX) ? seen_q + 4'd1 : seen_q;
	assign is_push  = (cmd_q == kfc_pkg::CMD_PUSH);
	assign key      = is_push ? kmer_q : qk_q;
	assign mod_in   = key;
	assign idx_nx   = ((idx_q + 1'b1) == (AB+1)'(meff)) ? '0 : idx_q + 1'b1;
	assign match    = rdata.used && (rdata.key == key);
	assign free     = !rdata.used;
	assign cnt_inc  = (rdata.count < kfc_pkg::COUNT_MAX) ? rdata.count + 1'b1 : rdata.count;
	assign raddr    = idx_q[AB-1:0];
	assign acc_value = (in_item.cmd == kfc_pkg::CMD_PUSH && new_seen >= keff)
	                   ? (new_roll & kmask) : '0;

	assign in_item.ready = (state_q == kfc_pkg::ST_IDLE) && !ovalid_q;
	assign out_res.valid = ovalid_q;
	assign out_res.kmer_valid = res_q.kmer_valid;
	assign out_res.kmer_value = res_q.kmer_value;
	assign out_res.hit_count  = res_q.hit_count;
	assign out_res.best_kmer  = res_q.best_kmer;
	assign out_res.best_count = res_q.best_count;
	assign out_res.table_full = res_q.table_full;

	// next state and memory controls
	always_comb begin
		state_d   = state_q;
		mod_start = 1'b0;
		we        = 1'b0;
		waddr     = idx_q[AB-1:0];
		wdata     = rdata;
		case (state_q)
			kfc_pkg::ST_WIPE: begin
				we    = 1'b1;
				waddr = wipe_q[AB-1:0];
				wdata = '0;
				// the wipe after reset owes no word; the one for a clear does
				if (wipe_q == (AB+1)'(kfc_pkg::TABLE_DEPTH - 1))
					state_d = boot_q ? kfc_pkg::ST_IDLE : kfc_pkg::ST_OUT;
			end
			kfc_pkg::ST_IDLE: ;
			kfc_pkg::ST_MOD: if (mod_done) state_d = kfc_pkg::ST_RD;
			kfc_pkg::ST_RD: state_d = kfc_pkg::ST_WAIT;
			kfc_pkg::ST_WAIT: state_d = kfc_pkg::ST_CHECK;
			kfc_pkg::ST_CHECK: begin
				if (direct) begin
					if (is_push) begin
						we    = 1'b1;
						wdata = '{used: rdata.used, key: rdata.key, count: cnt_inc};
					end
					state_d = kfc_pkg::ST_OUT;
				end else if (match || free) begin
					if (is_push) begin
						we    = 1'b1;
						wdata = match ? '{used: 1'b1, key: key, count: cnt_inc}
						              : '{used: 1'b1, key: key, count: CB'(1)};
					end
					state_d = kfc_pkg::ST_OUT;
				end else if (probes_q + 1'b1 == (AB+1)'(meff)) begin
					state_d = kfc_pkg::ST_OUT;
				end else begin
					state_d = kfc_pkg::ST_RD;
				end
			end
			kfc_pkg::ST_OUT: state_d = kfc_pkg::ST_IDLE;
			default: state_d = kfc_pkg::ST_IDLE;
		endcase
		if (state_q == kfc_pkg::ST_IDLE && accept) begin
			case (in_item.cmd)
				kfc_pkg::CMD_CLEAR: state_d = kfc_pkg::ST_WIPE;
				kfc_pkg::CMD_PUSH: begin
					if (new_seen >= keff) begin
						if (direct) state_d = kfc_pkg::ST_RD;
						else begin
							state_d   = kfc_pkg::ST_MOD;
						end
					end else state_d = kfc_pkg::ST_OUT;
				end
				kfc_pkg::CMD_QUERY: begin
					if (!direct) state_d = kfc_pkg::ST_MOD;
					else if ((in_item.query_kmer & ~kmask) != '0) state_d = kfc_pkg::ST_OUT;
					else state_d = kfc_pkg::ST_RD;
				end
				default: state_d = kfc_pkg::ST_OUT;
			endcase
		end
		// start the remainder in the cycle after the key register is loaded
		if (state_q == kfc_pkg::ST_MOD && !mod_busy_q) mod_start = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mod_busy_q <= 1'b0;
		else if (mod_start) mod_busy_q <= 1'b1;
		else if (mod_done) mod_busy_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kfc_pkg::ST_WIPE;
			wipe_q      <= '0;
			boot_q      <= 1'b1;
			roll_q      <= '0;
			seen_q      <= '0;
			best_kmer_q <= '0;
			best_cnt_q  <= '0;
			full_q      <= 1'b0;
			ovalid_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_res.valid && out_res.ready) ovalid_q <= 1'b0;
			case (state_q)
				kfc_pkg::ST_WIPE: wipe_q <= wipe_q + 1'b1;
				kfc_pkg::ST_IDLE: if (accept) begin
					wipe_q <= '0;
					boot_q <= 1'b0;
					case (in_item.cmd)
						kfc_pkg::CMD_CLEAR: begin
							roll_q      <= '0;
							seen_q      <= '0;
							best_kmer_q <= '0;
							best_cnt_q  <= '0;
							full_q      <= 1'b0;
						end
						kfc_pkg::CMD_PUSH: begin
							roll_q <= new_roll;
							seen_q <= new_seen;
						end
						default: ;
					endcase
				end
				kfc_pkg::ST_CHECK: begin
					if (is_push && (direct || match || free)) begin
						if (best_cnt_q < wdata.count) begin
							best_cnt_q  <= wdata.count;
							best_kmer_q <= key;
						end
					end else if (is_push && !direct && probes_q + 1'b1 == (AB+1)'(meff)) begin
						full_q <= 1'b1;
					end
				end
				kfc_pkg::ST_OUT: ovalid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// payload registers: item, probe index and result word
	always_ff @(posedge clk) begin
		if (state_q == kfc_pkg::ST_IDLE && accept) begin
			cmd_q    <= in_item.cmd;
			qk_q     <= in_item.query_kmer;
			kmer_q   <= new_roll & kmask;
			probes_q <= '0;
			idx_q    <= (in_item.cmd == kfc_pkg::CMD_PUSH) ? (AB+1)'(new_roll & kmask)
			                                               : (AB+1)'(in_item.query_kmer);
			res_q    <= '{kmer_valid: 1'b0, kmer_value: acc_value, hit_count: '0,
			              best_kmer: '0, best_count: '0, table_full: 1'b0};
		end
		if (state_q == kfc_pkg::ST_MOD && mod_done) idx_q <= (AB+1)'(mod_rem);
		if (state_q == kfc_pkg::ST_CHECK) begin
			if (direct || match || free) begin
				if (is_push) begin
					res_q.kmer_valid <= 1'b1;
					res_q.hit_count  <= wdata.count;
				end else begin
					res_q.hit_count  <= (direct || match) ? rdata.count : '0;
				end
			end else begin
				idx_q    <= idx_nx;
				probes_q <= probes_q + 1'b1;
			end
		end
		if (state_q == kfc_pkg::ST_OUT) begin
			res_q.best_kmer  <= best_kmer_q;
			res_q.best_count <= best_cnt_q;
			res_q.table_full <= full_q;
		end
	end
endmodule

[tb/sv/kfc_tb_if.sv]
// Testbench clock and reset bundle.
`timescale 1ns / 1ps
interface kfc_tb_clk_if;
	logic clk;
	logic arst_n;
endinterface

[tb/sv/testbench.sv]
// Testbench: drives the k-mer counter with items and config writes, and checks every result word.
`timescale 1ns / 1ps
module testbench;
	import kfc_pkg::*;

	localparam int LIMIT_CYCLES = 3000000;
	localparam int HOLD_CYCLES  = 400;

	logic clk;
	logic arst_n;

	kfc_tb_clk_if tb_clk ();
	kfc_item_if   in_item ();
	kfc_result_if out_res ();
	kfc_cfg_if    cfg ();

	assign clk    = tb_clk.clk;
	assign arst_n = tb_clk.arst_n;

	kmer_frequency_counter_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_item (in_item.sink),
		.out_res (out_res.source),
		.cfg     (cfg.sink)
	);

	// Items waiting to go onto the bus, and the result words owed by the block.
	item_t   pending_items[$];
	result_t owed_words[$];

	// Shadow of the block's registers and state.
	logic [3:0]      sh_kmer_len;
	logic [3:0]      sh_direct_max_k;
	logic [17:0]     sh_modulus;
	bit              tbl_used[int];
	bit [29:0]       tbl_key[int];
	bit [19:0]       tbl_count[int];
	logic [29:0]     sh_roll;
	int unsigned     sh_seen;
	logic [29:0]     sh_best_kmer;
	logic [19:0]     sh_best_count;
	bit              sh_full;

	int  fail_count;
	int  cycle_count;
	bit  no_idle;
	bit  hold_enable;
	bit  hold_active;
	int  hold_cycles;

	// Generator's own view of the rolling k-mer, for queries that hit.
	logic [29:0] gen_roll;

	initial begin
		tb_clk.clk = 1'b0;
		forever #6 tb_clk.clk = ~tb_clk.clk;
	end

	function automatic int unsigned active_k();
		int unsigned k;
		k = sh_kmer_len;
		if (k == 0) k = 1;
		if (k > K_MAX) k = K_MAX;
		return k;
	endfunction

	function automatic int unsigned active_modulus();
		int unsigned m;
		m = sh_modulus;
		if (m == 0) m = 1;
		if (m > TABLE_DEPTH) m = TABLE_DEPTH;
		return m;
	endfunction

	function automatic bit is_direct(int unsigned k);
		return (k <= sh_direct_max_k) && ((64'd1 << (2 * k)) <= TABLE_DEPTH);
	endfunction

	function automatic bit [19:0] count_of(int idx);
		return tbl_count.exists(idx) ? tbl_count[idx] : 20'd0;
	endfunction

	// Count one k-mer; give back the new count, or 0 when no slot can hold it.
	function automatic bit [19:0] tally_kmer(logic [29:0] kmer, int unsigned k);
		int unsigned m, idx, j;
		bit          placed;
		if (is_direct(k)) begin
			idx = kmer;
		end else begin
			m = active_modulus();
			idx = kmer % m;
			placed = 0;
			for (j = 0; j < m; j++) begin
				if (!(tbl_used.exists(idx) && tbl_used[idx])) begin
					tbl_used[idx] = 1;
					tbl_key[idx] = kmer;
					tbl_count[idx] = 0;
					placed = 1;
					break;
				end
				if (tbl_key[idx] == kmer) begin
					placed = 1;
					break;
				end
				idx = (idx + 1) % m;
			end
			if (!placed) begin
				sh_full = 1;
				return 0;
			end
		end
		if (count_of(idx) != COUNT_MAX) tbl_count[idx] = count_of(idx) + 1;
		return tbl_count[idx];
	endfunction

	function automatic bit [19:0] count_lookup(logic [29:0] q, int unsigned k);
		int unsigned m, idx, j;
		if (is_direct(k)) begin
			if (64'(q) >= (64'd1 << (2 * k))) return 0;
			return count_of(q);
		end
		m = active_modulus();
		idx = q % m;
		for (j = 0; j < m; j++) begin
			if (!(tbl_used.exists(idx) && tbl_used[idx])) return 0;
			if (tbl_key[idx] == q) return count_of(idx);
			idx = (idx + 1) % m;
		end
		return 0;
	endfunction

	// Advance the shadow by one accepted item and give back the owed word.
	function automatic result_t predict_word(logic [1:0] c, logic [1:0] b, logic [29:0] q);
		result_t     w;
		int unsigned k;
		logic [29:0] value;
		bit   [19:0] hit;
		k = active_k();
		w = '0;
		value = '0;
		hit = '0;
		case (cmd_t'(c))
			CMD_CLEAR: begin
				tbl_used.delete();
				tbl_count.delete();
				sh_roll = '0;
				sh_seen = 0;
				sh_best_kmer = '0;
				sh_best_count = '0;
				sh_full = 0;
			end
			CMD_PUSH: begin
				sh_roll = {sh_roll[27:0], b};
				if (sh_seen < K_MAX) sh_seen++;
				if (sh_seen >= k) begin
					value = 30'((64'(sh_roll)) & ((64'd1 << (2 * k)) - 1));
					hit = tally_kmer(value, k);
					if (hit != 0) begin
						w.kmer_valid = 1'b1;
						if (sh_best_count < hit) begin
							sh_best_count = hit;
							sh_best_kmer = value;
						end
					end
				end
			end
			CMD_QUERY: hit = count_lookup(q, k);
			default: ;
		endcase
		w.kmer_value = value;
		w.hit_count  = hit;
		w.best_kmer  = sh_best_kmer;
		w.best_count = sh_best_count;
		w.table_full = sh_full;
		return w;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_count);
		fail_count++;
	endtask

	// Driver: predict on each accepted word, then load the next one or idle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_item.valid      <= 1'b0;
			in_item.cmd        <= CMD_NONE;
			in_item.base       <= '0;
			in_item.query_kmer <= '0;
		end else begin
			item_t nxt;
			if (in_item.valid && in_item.ready)
				owed_words.push_back(predict_word(in_item.cmd, in_item.base,
					in_item.query_kmer));
			if (!in_item.valid || in_item.ready) begin
				if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= 37)) begin
					nxt = pending_items.pop_front();
					in_item.valid      <= 1'b1;
					in_item.cmd        <= nxt.cmd;
					in_item.base       <= nxt.base;
					in_item.query_kmer <= nxt.query_kmer;
				end else begin
					in_item.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted result word against the oldest owed word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_res.ready <= 1'b0;
		end else begin
			result_t want;
			if (out_res.valid && out_res.ready) begin
				if (owed_words.size() == 0) begin
					report_mismatch("unexpected word", out_res.hit_count, 0);
				end else begin
					want = owed_words.pop_front();
					if (out_res.kmer_valid !== want.kmer_valid)
						report_mismatch("kmer_valid", out_res.kmer_valid, want.kmer_valid);
					if (out_res.kmer_value !== want.kmer_value)
						report_mismatch("kmer_value", out_res.kmer_value, want.kmer_value);
					if (out_res.hit_count !== want.hit_count)
						report_mismatch("hit_count", out_res.hit_count, want.hit_count);
					if (out_res.best_kmer !== want.best_kmer)
						report_mismatch("best_kmer", out_res.best_kmer, want.best_kmer);
					if (out_res.best_count !== want.best_count)
						report_mismatch("best_count", out_res.best_count, want.best_count);
					if (out_res.table_full !== want.table_full)
						report_mismatch("table_full", out_res.table_full, want.table_full);
				end
			end
			out_res.ready <= !hold_active && (no_idle || $urandom_range(99) >= 37);
		end
	end

	// Hold off the receiver once for a long stretch so the block backs up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_active <= 1'b0;
			hold_cycles <= 0;
		end else if (hold_enable && hold_cycles < HOLD_CYCLES) begin
			hold_active <= 1'b1;
			hold_cycles <= hold_cycles + 1;
		end else begin
			hold_active <= 1'b0;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("** kmer_frequency_counter_core: FAILED **");
			$finish;
		end
	end

	task automatic add_item(cmd_t c, logic [1:0] b, logic [29:0] q);
		item_t it;
		it.cmd = c;
		it.base = b;
		it.query_kmer = q;
		pending_items.push_back(it);
		if (c == CMD_PUSH) gen_roll = {gen_roll[27:0], b};
		if (c == CMD_CLEAR) gen_roll = '0;
	endtask

	// Wait until every queued item went in and every owed word came back.
	task automatic drain();
		do @(posedge clk);
		while (pending_items.size() != 0 || in_item.valid || owed_words.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	// Hold valid between back-to-back writes; set_mode drops it after the last.
	task automatic write_reg(reg_idx_t idx, logic [31:0] data);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk);
		while (!cfg.ready);
		case (idx)
			REG_KMER_LEN:     sh_kmer_len = data[3:0];
			REG_DIRECT_MAX_K: sh_direct_max_k = data[3:0];
			REG_HASH_MODULUS: sh_modulus = data[17:0];
			default: ;
		endcase
	endtask

	task automatic set_mode(logic [3:0] k, logic [3:0] dmk, logic [17:0] m);
		write_reg(REG_KMER_LEN, k);
		write_reg(REG_DIRECT_MAX_K, dmk);
		write_reg(REG_HASH_MODULUS, m);
		cfg.valid <= 1'b0;
	endtask

	// Random items: mostly pushes, queries that often hit, a little noise.
	task automatic random_items(int n);
		int          r;
		logic [29:0] q;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 70) begin
				add_item(CMD_PUSH, 2'($urandom_range(3)), '0);
			end else if (r < 92) begin
				case ($urandom_range(2))
					0: q = 30'((64'(gen_roll)) & ((64'd1 << (2 * active_k())) - 1));
					1: q = 30'($urandom);
					default: q = 30'($urandom_range(255));
				endcase
				add_item(CMD_QUERY, 2'($urandom_range(3)), q);
			end else begin
				add_item(CMD_NONE, 2'($urandom_range(3)), 30'($urandom));
			end
		end
	endtask

	initial begin
		// Drive every input known and hold reset.
		tb_clk.arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_KMER_LEN;
		cfg.data = '0;
		fail_count = 0;
		cycle_count = 0;
		no_idle = 0;
		hold_enable = 0;
		gen_roll = '0;
		sh_kmer_len = 4'd12;
		sh_direct_max_k = 4'd9;
		sh_modulus = 18'd4001;
		sh_roll = '0;
		sh_seen = 0;
		sh_best_kmer = '0;
		sh_best_count = '0;
		sh_full = 0;
		repeat (9) @(posedge clk);
		tb_clk.arst_n <= 1'b1;

		// Reset settings: hashed, k = 12. Empty-table queries, both extremes.
		add_item(CMD_NONE, 2'd3, 30'h3FFFFFFF);
		add_item(CMD_QUERY, 2'd0, 30'd0);
		add_item(CMD_QUERY, 2'd3, 30'h3FFFFFFF);
		for (int i = 0; i < 13; i++) add_item(CMD_PUSH, 2'd3, '0);
		add_item(CMD_QUERY, 2'd0, 30'hFFFFFF);
		add_item(CMD_PUSH, 2'd0, '0);
		add_item(CMD_PUSH, 2'd1, '0);
		add_item(CMD_PUSH, 2'd2, '0);
		drain();

		// Direct mode, k = 1: each base is its own k-mer; query past the range.
		set_mode(4'd1, 4'd9, 18'd4001);
		for (int i = 0; i < 4; i++) add_item(CMD_PUSH, 2'(i), '0);
		add_item(CMD_PUSH, 2'd2, '0);
		add_item(CMD_QUERY, 2'd0, 30'd2);
		add_item(CMD_QUERY, 2'd0, 30'd4);
		drain();

		// Three-slot hashed table: distinct k-mers overflow it and set full.
		set_mode(4'd2, 4'd0, 18'd3);
		for (int i = 0; i < 10; i++) add_item(CMD_PUSH, 2'(i * 3), '0);
		add_item(CMD_QUERY, 2'd0, 30'd15);
		add_item(CMD_CLEAR, 2'd0, '0);
		add_item(CMD_QUERY, 2'd0, 30'd15);
		drain();

		// Random phases over a spread of settings; the overflowing ones come last.
		set_mode(4'd3, 4'd9, 18'd1009);
		no_idle = 1;
		random_items(125);
		drain();
		no_idle = 0;

		set_mode(4'd15, 4'd0, 18'd262143);
		hold_enable = 1;
		random_items(125);
		drain();

		set_mode(4'd6, 4'd6, 18'd1009);
		random_items(125);
		drain();

		set_mode(4'd5, 4'd4, 18'd4001);
		random_items(125);
		drain();

		set_mode(4'd4, 4'd0, 18'd7);
		random_items(125);
		drain();

		set_mode(4'd0, 4'd0, 18'd0);
		random_items(125);
		drain();

		repeat (100) @(posedge clk);
		if (fail_count == 0 && owed_words.size() == 0)
			$display("** kmer_frequency_counter_core: PASSED **");
		else
			$display("** kmer_frequency_counter_core: FAILED **");
		$finish;
	end
endmodule
